// ===== hw/rtl/mmbrl_pkg.sv =====
// Package for the multi-mode byte rate limiter.
// Holds item and result types, codes and shared constants; no dependencies.
package mmbrl_pkg;

   localparam int WINDOW_ENTRIES_DEF = 64;
   localparam int NUM_W = 27;
   localparam int CSR_INDEX_W = 2;

   localparam logic [1:0] MODE_TOKEN   = 2'd0;
   localparam logic [1:0] MODE_LEAKY   = 2'd1;
   localparam logic [1:0] MODE_SLIDING = 2'd2;
   localparam logic [1:0] MODE_FIXED   = 2'd3;

   localparam logic [2:0] ACT_ACQUIRE = 3'd0;
   localparam logic [2:0] ACT_CHECK   = 3'd1;
   localparam logic [2:0] ACT_WAIT    = 3'd2;
   localparam logic [2:0] ACT_TICK    = 3'd3;
   localparam logic [2:0] ACT_RESET   = 3'd4;
   localparam logic [2:0] ACT_CLEAR   = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST = 2'd2;

   localparam logic [31:0] RATE_RST  = 32'd1048576;
   localparam logic [31:0] BURST_RST = 32'd1048576;
   localparam logic [31:0] WIN_MS    = 32'd1000;

   typedef enum logic [2:0] {
      OP_ACQUIRE, OP_CHECK, OP_WAIT, OP_TICK, OP_RESET, OP_CLEAR, OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SUM, ST_PURGE_RD, ST_PURGE_CHK, ST_DECIDE, ST_DIV
   } state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] byte_count;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        allowed;
      logic [30:0] wait_ms;
      logic        status;
      logic [63:0] bytes_allowed_total;
      logic [63:0] bytes_rejected_total;
      logic [31:0] mode_rejections;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic        zero_count;
      logic [15:0] byte_count;
      logic [31:0] now_ms;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   function automatic logic [35:0] times_ten(input logic [31:0] v);
      return ({4'b0, v} << 3) + ({4'b0, v} << 1);
   endfunction

endpackage

// ===== hw/rtl/mmbrl_front.sv =====
// Front end: decodes incoming items and holds them in a two-entry queue.
// Depends on mmbrl_pkg.
module mmbrl_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mmbrl_pkg::req_type      req_item,
   input  logic                    pop,
   output mmbrl_pkg::queue_out_type q_out
);

   mmbrl_pkg::cmd_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   mmbrl_pkg::cmd_type cmd;
   logic               push;

   always_comb begin
      cmd.byte_count = req_item.byte_count;
      cmd.now_ms     = req_item.now_ms;
      cmd.zero_count = (req_item.byte_count == 16'd0);
      unique case (req_item.action)
         mmbrl_pkg::ACT_ACQUIRE: cmd.op = mmbrl_pkg::OP_ACQUIRE;
         mmbrl_pkg::ACT_CHECK:   cmd.op = mmbrl_pkg::OP_CHECK;
         mmbrl_pkg::ACT_WAIT:    cmd.op = mmbrl_pkg::OP_WAIT;
         mmbrl_pkg::ACT_TICK:    cmd.op = mmbrl_pkg::OP_TICK;
         mmbrl_pkg::ACT_RESET:   cmd.op = mmbrl_pkg::OP_RESET;
         mmbrl_pkg::ACT_CLEAR:   cmd.op = mmbrl_pkg::OP_CLEAR;
         default:                cmd.op = mmbrl_pkg::OP_NONE;
      endcase
   end

   assign busy  = (count_ff == 2'd2);
   assign push  = start && !busy;
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ===== hw/rtl/mmbrl_back.sv =====
// Back end: limiter state, window ring, serial divider and result register.
// Depends on mmbrl_pkg.
module mmbrl_back #(
   parameter int WINDOW_ENTRIES = mmbrl_pkg::WINDOW_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mmbrl_pkg::queue_out_type             q_in,
   output logic                                 pop,
   input  logic                                 csr_we,
   input  logic [mmbrl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                          csr_wdata,
   output logic                                 rsp_valid,
   output mmbrl_pkg::rsp_type                   rsp_item
);

   localparam int AW = $clog2(WINDOW_ENTRIES);
   localparam int CW = $clog2(WINDOW_ENTRIES + 1);
   localparam int SW = 16 + CW;
   localparam int NW = mmbrl_pkg::NUM_W;
   localparam int DW = $clog2(NW + 1);

   function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [CW-1:0] off);
      logic [AW:0] s;
      s = {1'b0, base} + (AW+1)'(off);
      if (s >= (AW+1)'(WINDOW_ENTRIES)) begin
         s = s - (AW+1)'(WINDOW_ENTRIES);
      end
      return s[AW-1:0];
   endfunction

   logic [1:0]           mode_ff, mode_in;
   logic [31:0]          rate_ff, rate_in;
   logic [31:0]          burst_ff, burst_in;
   logic [35:0]          tok_ff, tok_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [31:0]          fstart_ff, fstart_in;
   logic [32:0]          fused_ff, fused_in;
   logic [63:0]          asum_ff, asum_in;
   logic [63:0]          rsum_ff, rsum_in;
   logic [31:0]          rej_ff [4];
   logic [31:0]          rej_in [4];
   mmbrl_pkg::state_type state_ff, state_in;
   mmbrl_pkg::cmd_type   cmd_ff, cmd_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [SW-1:0]        used_ff, used_in;
   logic [31:0]          rem_ff, rem_in;
   logic [NW-1:0]        num_ff, num_in;
   logic [DW-1:0]        dcnt_ff, dcnt_in;
   mmbrl_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [31:0]          mem_time [WINDOW_ENTRIES];
   logic [15:0]          mem_bytes [WINDOW_ENTRIES];
   logic [31:0]          rd_time_ff;
   logic [15:0]          rd_bytes_ff;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic                 mem_we;

   logic [31:0]          csr_val;
   logic [35:0]          burst10;
   logic [35:0]          new_burst10;
   logic [31:0]          age;
   logic [19:0]          bc10;
   logic [31:0]          fage;
   logic                 fexp;
   logic [32:0]          fused_eff;
   logic [33:0]          used_eff;
   logic [33:0]          remaining;
   logic                 quota;
   logic                 ok;
   logic                 need_div;
   logic [NW-1:0]        num;
   logic [19:0]          deficit;
   logic [30:0]          wait_direct;
   logic [36:0]          tok_sum;
   logic [32:0]          rem_sh;
   logic                 qbit;

   assign csr_val     = (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
   assign burst10     = mmbrl_pkg::times_ten(burst_ff);
   assign new_burst10 = mmbrl_pkg::times_ten(csr_val);
   assign rd_addr     = (state_ff == mmbrl_pkg::ST_SUM) ? ring(head_ff, idx_ff) : head_ff;
   assign wr_addr     = ring(head_ff, fill_ff);
   assign age         = cmd_ff.now_ms - rd_time_ff;
   assign bc10        = ({4'b0, cmd_ff.byte_count} << 3) + ({4'b0, cmd_ff.byte_count} << 1);
   assign fage        = cmd_ff.now_ms - fstart_ff;
   assign fexp        = (fage >= mmbrl_pkg::WIN_MS);
   assign fused_eff   = fexp ? 33'd0 : fused_ff;
   assign used_eff    = (mode_ff == mmbrl_pkg::MODE_SLIDING) ? 34'(used_ff) : {1'b0, fused_eff};
   assign remaining   = (used_eff < {2'b0, rate_ff}) ? ({2'b0, rate_ff} - used_eff) : 34'd0;
   assign tok_sum     = {1'b0, tok_ff} + 37'(rate_ff);
   assign rem_sh      = {rem_ff, num_ff[NW-1]};
   assign qbit        = (rem_sh >= {1'b0, rate_ff});

   always_comb begin
      unique case (mode_ff)
         mmbrl_pkg::MODE_TOKEN: quota = (tok_ff >= 36'(bc10));
         mmbrl_pkg::MODE_LEAKY: quota = (32'(bc10) <= rate_ff);
         default:               quota = (used_eff + 34'(cmd_ff.byte_count)) <= 34'(rate_ff);
      endcase
   end

   always_comb begin
      need_div    = 1'b0;
      deficit     = 20'd0;
      num         = '0;
      wait_direct = 31'd0;
      unique case (mode_ff)
         mmbrl_pkg::MODE_TOKEN: begin
            if (tok_ff < 36'(bc10)) begin
               need_div = 1'b1;
               deficit  = bc10 - tok_ff[19:0];
               num      = NW'(deficit) * NW'(100);
            end
         end
         mmbrl_pkg::MODE_LEAKY: begin
            if (32'(bc10) > rate_ff) begin
               need_div = 1'b1;
               deficit  = bc10 - rate_ff[19:0];
               num      = NW'(deficit) * NW'(100);
            end
         end
         mmbrl_pkg::MODE_SLIDING: begin
            if (remaining < 34'(cmd_ff.byte_count)) begin
               need_div = 1'b1;
               deficit  = 20'(cmd_ff.byte_count - remaining[15:0]);
               num      = NW'(deficit) * NW'(1000);
            end
         end
         default: begin
            if (remaining < 34'(cmd_ff.byte_count) && !fexp) begin
               wait_direct = 31'(mmbrl_pkg::WIN_MS - fage);
            end
         end
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      rate_in      = rate_ff;
      burst_in     = burst_ff;
      tok_in       = tok_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      fstart_in    = fstart_ff;
      fused_in     = fused_ff;
      asum_in      = asum_ff;
      rsum_in      = rsum_ff;
      rej_in       = rej_ff;
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      used_in      = used_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      dcnt_in      = dcnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      pop          = 1'b0;
      mem_we       = 1'b0;
      ok           = 1'b0;

      if (csr_we) begin
         case (csr_index)
            mmbrl_pkg::CSR_MODE: begin
               mode_in   = csr_wdata[1:0];
               tok_in    = burst10;
               head_in   = '0;
               fill_in   = '0;
               fstart_in = 32'd0;
               fused_in  = 33'd0;
            end
            mmbrl_pkg::CSR_RATE: begin
               rate_in = csr_val;
            end
            mmbrl_pkg::CSR_BURST: begin
               burst_in = csr_val;
               if (tok_ff > new_burst10) begin
                  tok_in = new_burst10;
               end
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         mmbrl_pkg::ST_IDLE: begin
            if (q_in.valid) begin
               pop     = 1'b1;
               cmd_in  = q_in.cmd;
               idx_in  = '0;
               pend_in = 1'b0;
               used_in = '0;
               if (mode_ff == mmbrl_pkg::MODE_SLIDING && !q_in.cmd.zero_count &&
                   (q_in.cmd.op == mmbrl_pkg::OP_ACQUIRE || q_in.cmd.op == mmbrl_pkg::OP_CHECK ||
                    q_in.cmd.op == mmbrl_pkg::OP_WAIT)) begin
                  state_in = mmbrl_pkg::ST_SUM;
               end else if (mode_ff == mmbrl_pkg::MODE_SLIDING &&
                            q_in.cmd.op == mmbrl_pkg::OP_TICK) begin
                  state_in = mmbrl_pkg::ST_PURGE_RD;
               end else begin
                  state_in = mmbrl_pkg::ST_DECIDE;
               end
            end
         end
         mmbrl_pkg::ST_SUM: begin
            pend_in = (idx_ff != fill_ff);
            if (idx_ff != fill_ff) begin
               idx_in = idx_ff + CW'(1);
            end
            if (pend_ff && (age <= mmbrl_pkg::WIN_MS || age[31])) begin
               used_in = used_ff + SW'(rd_bytes_ff);
            end
            if (idx_ff == fill_ff && !pend_ff) begin
               state_in = mmbrl_pkg::ST_DECIDE;
            end
         end
         mmbrl_pkg::ST_PURGE_RD: begin
            state_in = (fill_ff == '0) ? mmbrl_pkg::ST_DECIDE : mmbrl_pkg::ST_PURGE_CHK;
         end
         mmbrl_pkg::ST_PURGE_CHK: begin
            if (age > mmbrl_pkg::WIN_MS && !age[31]) begin
               head_in  = ring(head_ff, CW'(1));
               fill_in  = fill_ff - CW'(1);
               state_in = mmbrl_pkg::ST_PURGE_RD;
            end else begin
               state_in = mmbrl_pkg::ST_DECIDE;
            end
         end
         mmbrl_pkg::ST_DECIDE: begin
            rsp_in.allowed = 1'b0;
            rsp_in.wait_ms = 31'd0;
            rsp_in.status  = 1'b0;
            state_in       = mmbrl_pkg::ST_IDLE;
            rsp_valid_in   = 1'b1;
            case (cmd_ff.op)
               mmbrl_pkg::OP_ACQUIRE: begin
                  if (cmd_ff.zero_count) begin
                     rsp_in.allowed = 1'b1;
                  end else begin
                     if (mode_ff == mmbrl_pkg::MODE_FIXED && fexp) begin
                        fstart_in = cmd_ff.now_ms;
                        fused_in  = 33'd0;
                     end
                     ok = quota;
                     if (ok && mode_ff == mmbrl_pkg::MODE_SLIDING &&
                         fill_ff == CW'(WINDOW_ENTRIES)) begin
                        ok            = 1'b0;
                        rsp_in.status = 1'b1;
                     end
                     if (ok) begin
                        rsp_in.allowed = 1'b1;
                        asum_in        = asum_ff + 64'(cmd_ff.byte_count);
                        case (mode_ff)
                           mmbrl_pkg::MODE_TOKEN: tok_in = tok_ff - 36'(bc10);
                           mmbrl_pkg::MODE_SLIDING: begin
                              mem_we  = 1'b1;
                              fill_in = fill_ff + CW'(1);
                           end
                           mmbrl_pkg::MODE_FIXED: fused_in = fused_eff + 33'(cmd_ff.byte_count);
                           default: begin
                           end
                        endcase
                     end else begin
                        rsum_in          = rsum_ff + 64'(cmd_ff.byte_count);
                        rej_in[mode_ff]  = rej_ff[mode_ff] + 32'd1;
                     end
                  end
               end
               mmbrl_pkg::OP_CHECK: begin
                  rsp_in.allowed = cmd_ff.zero_count || quota;
               end
               mmbrl_pkg::OP_WAIT: begin
                  if (!cmd_ff.zero_count) begin
                     if (need_div) begin
                        num_in       = num;
                        rem_in       = 32'd0;
                        dcnt_in      = '0;
                        state_in     = mmbrl_pkg::ST_DIV;
                        rsp_valid_in = 1'b0;
                     end else begin
                        rsp_in.wait_ms = wait_direct;
                     end
                  end
               end
               mmbrl_pkg::OP_TICK: begin
                  if (mode_ff == mmbrl_pkg::MODE_TOKEN) begin
                     tok_in = (tok_sum > {1'b0, burst10}) ? burst10 : tok_sum[35:0];
                  end
               end
               mmbrl_pkg::OP_RESET: begin
                  tok_in    = burst10;
                  head_in   = '0;
                  fill_in   = '0;
                  fstart_in = cmd_ff.now_ms;
                  fused_in  = 33'd0;
               end
               mmbrl_pkg::OP_CLEAR: begin
                  asum_in = 64'd0;
                  rsum_in = 64'd0;
                  for (int i = 0; i < 4; i++) begin
                     rej_in[i] = 32'd0;
                  end
               end
               default: begin
               end
            endcase
            rsp_in.bytes_allowed_total  = asum_in;
            rsp_in.bytes_rejected_total = rsum_in;
            rsp_in.mode_rejections      = rej_in[mode_ff];
         end
         mmbrl_pkg::ST_DIV: begin
            rem_in  = qbit ? 32'(rem_sh - {1'b0, rate_ff}) : rem_sh[31:0];
            num_in  = {num_ff[NW-2:0], qbit};
            dcnt_in = dcnt_ff + DW'(1);
            if (dcnt_ff == DW'(NW - 1)) begin
               rsp_in.wait_ms = 31'(num_in);
               rsp_valid_in   = 1'b1;
               state_in       = mmbrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmbrl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mmbrl_pkg::MODE_TOKEN;
         rate_ff      <= mmbrl_pkg::RATE_RST;
         burst_ff     <= mmbrl_pkg::BURST_RST;
         tok_ff       <= mmbrl_pkg::times_ten(mmbrl_pkg::BURST_RST);
         head_ff      <= '0;
         fill_ff      <= '0;
         fstart_ff    <= 32'd0;
         fused_ff     <= 33'd0;
         asum_ff      <= 64'd0;
         rsum_ff      <= 64'd0;
         for (int i = 0; i < 4; i++) begin
            rej_ff[i] <= 32'd0;
         end
         state_ff     <= mmbrl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rate_ff      <= rate_in;
         burst_ff     <= burst_in;
         tok_ff       <= tok_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         fstart_ff    <= fstart_in;
         fused_ff     <= fused_in;
         asum_ff      <= asum_in;
         rsum_ff      <= rsum_in;
         rej_ff       <= rej_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      used_ff <= used_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      dcnt_ff <= dcnt_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_time[wr_addr]  <= cmd_ff.now_ms;
         mem_bytes[wr_addr] <= cmd_ff.byte_count;
      end
      rd_time_ff  <= mem_time[rd_addr];
      rd_bytes_ff <= mem_bytes[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== hw/rtl/multi_mode_byte_rate_limiter.sv =====
// Channel   Handshake                 Payload
// request   start / busy              req_item  (action, byte_count, now_ms)
// response  rsp_valid strobe          rsp_item  (allowed, wait_ms, status, totals)
// config    csr_we, csr_index         csr_wdata (mode, rate, burst)
// An item moves from the queue through the back end's idle and decide states, where
// its result is registered. A sliding-window query first sums the window entries, a
// tick in sliding mode first purges expired head entries, and a wait query that
// divides runs the serial divider. The back end handles one item at a time.
// Reset is synchronous and active high; no clearing pass is needed.
// A two-entry queue takes items until full as the back end works; results cannot stall.
module multi_mode_byte_rate_limiter #(
   parameter int WINDOW_ENTRIES = mmbrl_pkg::WINDOW_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  mmbrl_pkg::req_type                req_item,
   output logic                              rsp_valid,
   output mmbrl_pkg::rsp_type                rsp_item,
   input  logic                              csr_we,
   input  logic [mmbrl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                       csr_wdata
);

   mmbrl_pkg::queue_out_type q;
   logic                     pop;

   mmbrl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .pop      (pop),
      .q_out    (q)
   );

   mmbrl_back #(
      .WINDOW_ENTRIES (WINDOW_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q),
      .pop       (pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multi_mode_byte_rate_limiter: drives rate-limit items and
// register phases, predicts each result in all four modes. Depends on mmbrl_pkg.
module tb_top;

   localparam logic [mmbrl_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;
   localparam int WIN_DEPTH = mmbrl_pkg::WINDOW_ENTRIES_DEF;
   localparam int STALL_LIMIT = 20000;
   localparam logic [63:0] WAIT_CAP = 64'h7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   mmbrl_pkg::req_type req_item = '0;
   logic rsp_valid;
   mmbrl_pkg::rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [mmbrl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   multi_mode_byte_rate_limiter dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // limiter shadow state
   logic [1:0]  lim_mode;
   logic [63:0] lim_rate, lim_burst, lim_tokens;
   logic [31:0] win_time [WIN_DEPTH];
   logic [15:0] win_bytes [WIN_DEPTH];
   int unsigned win_head, win_fill;
   logic [31:0] fix_start;
   logic [63:0] fix_used, sum_granted, sum_refused;
   logic [31:0] refusals [4];

   mmbrl_pkg::req_type pending_items[$];
   mmbrl_pkg::rsp_type expected_rsps[$];
   int gap = 0;
   bit quiet = 0;
   int errors = 0;
   int n_items = 0, n_rsps = 0, n_full = 0, n_granted = 0;
   int stall_cycles = 0;
   logic [31:0] now_ms = 0;
   int bc_scale = 100, ms_step = 20;

   function automatic void clear_limiter(input logic [31:0] t0);
      lim_tokens = lim_burst * 10;
      win_head = 0;
      win_fill = 0;
      fix_start = t0;
      fix_used = 0;
   endfunction

   function automatic bit in_window(input logic [31:0] t, input logic [31:0] now);
      logic [31:0] age;
      age = now - t;
      return age <= 32'd1000 || age >= 32'h8000_0000;
   endfunction

   function automatic logic [63:0] window_sum(input logic [31:0] now);
      logic [63:0] s;
      s = 0;
      for (int i = 0; i < win_fill; i++)
         if (in_window(win_time[(win_head + i) % WIN_DEPTH], now))
            s += win_bytes[(win_head + i) % WIN_DEPTH];
      return s;
   endfunction

   function automatic logic [63:0] fixed_sum(input logic [31:0] now);
      logic [31:0] age;
      age = now - fix_start;
      return (age >= 32'd1000) ? 64'd0 : fix_used;
   endfunction

   function automatic bit quota_fits(input logic [63:0] bc, input logic [31:0] now);
      case (lim_mode)
         mmbrl_pkg::MODE_TOKEN:   return lim_tokens >= bc * 10;
         mmbrl_pkg::MODE_LEAKY:   return bc * 10 <= lim_rate;
         mmbrl_pkg::MODE_SLIDING: return window_sum(now) + bc <= lim_rate;
         default:                 return fixed_sum(now) + bc <= lim_rate;
      endcase
   endfunction

   function automatic logic [63:0] wait_for(input logic [63:0] bc, input logic [31:0] now);
      logic [63:0] ms, used, room;
      logic [31:0] age;
      ms = 0;
      if (bc == 0) return 0;
      if (lim_mode == mmbrl_pkg::MODE_TOKEN) begin
         if (lim_tokens < bc * 10) ms = (bc * 10 - lim_tokens) * 100 / lim_rate;
      end else if (lim_mode == mmbrl_pkg::MODE_LEAKY) begin
         if (bc * 10 > lim_rate) ms = (bc * 10 - lim_rate) * 100 / lim_rate;
      end else begin
         used = (lim_mode == mmbrl_pkg::MODE_SLIDING) ? window_sum(now) : fixed_sum(now);
         room = (used < lim_rate) ? lim_rate - used : 0;
         if (room < bc) begin
            if (lim_mode == mmbrl_pkg::MODE_SLIDING) begin
               ms = (bc - room) * 1000 / lim_rate;
            end else begin
               age = now - fix_start;
               ms = (age >= 32'd1000) ? 64'd0 : 64'd1000 - age;
            end
         end
      end
      return (ms > WAIT_CAP) ? WAIT_CAP : ms;
   endfunction

   task automatic limit_item(input mmbrl_pkg::req_type r, output mmbrl_pkg::rsp_type o);
      logic [63:0] bc;
      logic [31:0] age;
      bit ok;
      int k;
      bc = {48'd0, r.byte_count};
      o = '0;
      case (r.action)
         mmbrl_pkg::ACT_ACQUIRE: begin
            if (bc == 0) begin
               o.allowed = 1;
            end else begin
               if (lim_mode == mmbrl_pkg::MODE_FIXED &&
                   (r.now_ms - fix_start) >= 32'd1000) begin
                  fix_start = r.now_ms;
                  fix_used = 0;
               end
               ok = quota_fits(bc, r.now_ms);
               if (ok && lim_mode == mmbrl_pkg::MODE_SLIDING && win_fill >= WIN_DEPTH) begin
                  ok = 0;
                  o.status = 1;
               end
               if (ok) begin
                  o.allowed = 1;
                  sum_granted += bc;
                  if (lim_mode == mmbrl_pkg::MODE_TOKEN) begin
                     lim_tokens -= bc * 10;
                  end else if (lim_mode == mmbrl_pkg::MODE_SLIDING) begin
                     k = (win_head + win_fill) % WIN_DEPTH;
                     win_time[k] = r.now_ms;
                     win_bytes[k] = r.byte_count;
                     win_fill++;
                  end else if (lim_mode == mmbrl_pkg::MODE_FIXED) begin
                     fix_used += bc;
                  end
               end else begin
                  sum_refused += bc;
                  refusals[lim_mode]++;
               end
            end
         end
         mmbrl_pkg::ACT_CHECK: o.allowed = (bc == 0) || quota_fits(bc, r.now_ms);
         mmbrl_pkg::ACT_WAIT: o.wait_ms = 31'(wait_for(bc, r.now_ms));
         mmbrl_pkg::ACT_TICK: begin
            if (lim_mode == mmbrl_pkg::MODE_TOKEN) begin
               lim_tokens += lim_rate;
               if (lim_tokens > lim_burst * 10) lim_tokens = lim_burst * 10;
            end else if (lim_mode == mmbrl_pkg::MODE_SLIDING) begin
               while (win_fill > 0) begin
                  age = r.now_ms - win_time[win_head];
                  if (!(age > 32'd1000 && age < 32'h8000_0000)) break;
                  win_head = (win_head + 1) % WIN_DEPTH;
                  win_fill--;
               end
            end
         end
         mmbrl_pkg::ACT_RESET: clear_limiter(r.now_ms);
         mmbrl_pkg::ACT_CLEAR: begin
            sum_granted = 0;
            sum_refused = 0;
            for (int m = 0; m < 4; m++) refusals[m] = 0;
         end
         default: ;
      endcase
      o.bytes_allowed_total = sum_granted;
      o.bytes_rejected_total = sum_refused;
      o.mode_rejections = refusals[lim_mode];
   endtask

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at rsp %0d: %s got %0h expected %0h", n_rsps, field, got, want);
      errors++;
   endtask

   task automatic csr_write(input logic [mmbrl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] val);
      logic [63:0] v;
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      v = (val == 0) ? 64'd1 : {32'd0, val};
      case (idx)
         mmbrl_pkg::CSR_MODE: begin
            lim_mode = val[1:0];
            clear_limiter(0);
         end
         mmbrl_pkg::CSR_RATE: lim_rate = v;
         mmbrl_pkg::CSR_BURST: begin
            lim_burst = v;
            if (lim_tokens > lim_burst * 10) lim_tokens = lim_burst * 10;
         end
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_rsps.size() > 0 || start)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic mmbrl_pkg::req_type rand_item();
      mmbrl_pkg::req_type r;
      int p;
      p = $urandom_range(0, 99);
      if (p < 75) now_ms += $urandom_range(0, ms_step);
      else if (p < 88) now_ms += $urandom_range(100, 1500);
      else if (p < 93) now_ms = $urandom;
      else now_ms -= $urandom_range(0, 60);
      r.now_ms = now_ms;
      p = $urandom_range(0, 99);
      if (p < 45) r.action = mmbrl_pkg::ACT_ACQUIRE;
      else if (p < 57) r.action = mmbrl_pkg::ACT_CHECK;
      else if (p < 72) r.action = mmbrl_pkg::ACT_WAIT;
      else if (p < 92) r.action = mmbrl_pkg::ACT_TICK;
      else if (p < 95) r.action = mmbrl_pkg::ACT_RESET;
      else if (p < 97) r.action = mmbrl_pkg::ACT_CLEAR;
      else r.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
      p = $urandom_range(0, 99);
      if (p < 65) r.byte_count = 16'($urandom_range(1, bc_scale));
      else if (p < 75) r.byte_count = 0;
      else if (p < 82) r.byte_count = 16'hFFFF;
      else r.byte_count = 16'($urandom);
      return r;
   endfunction

   always @(posedge clock) begin : drive_proc
      mmbrl_pkg::rsp_type e;
      if (reset) begin
         start <= 0;
         gap <= 0;
      end else begin
         if (start && !busy) begin
            limit_item(req_item, e);
            expected_rsps.push_back(e);
            n_items++;
         end
         if (start && busy) begin
         end else if (gap > 0) begin
            start <= 0;
            gap <= gap - 1;
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
            start <= 1;
            if (!quiet && $urandom_range(0, 4) == 0) gap <= $urandom_range(1, 8);
         end else begin
            start <= 0;
         end
      end
   end

   always @(posedge clock) begin : check_proc
      mmbrl_pkg::rsp_type w;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report("unexpected rsp", 0, 0);
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_item.allowed !== w.allowed) report("allowed", rsp_item.allowed, w.allowed);
            if (rsp_item.wait_ms !== w.wait_ms) report("wait_ms", rsp_item.wait_ms, w.wait_ms);
            if (rsp_item.status !== w.status) report("status", rsp_item.status, w.status);
            if (rsp_item.bytes_allowed_total !== w.bytes_allowed_total)
               report("bytes_allowed_total", rsp_item.bytes_allowed_total,
                      w.bytes_allowed_total);
            if (rsp_item.bytes_rejected_total !== w.bytes_rejected_total)
               report("bytes_rejected_total", rsp_item.bytes_rejected_total,
                      w.bytes_rejected_total);
            if (rsp_item.mode_rejections !== w.mode_rejections)
               report("mode_rejections", rsp_item.mode_rejections, w.mode_rejections);
            n_full += w.status;
            n_granted += w.allowed;
         end
         n_rsps++;
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stim_proc
      mmbrl_pkg::req_type r;
      logic [1:0]  ph_mode  [12] = '{mmbrl_pkg::MODE_TOKEN, mmbrl_pkg::MODE_TOKEN,
         mmbrl_pkg::MODE_TOKEN, mmbrl_pkg::MODE_LEAKY, mmbrl_pkg::MODE_LEAKY,
         mmbrl_pkg::MODE_SLIDING, mmbrl_pkg::MODE_SLIDING, mmbrl_pkg::MODE_SLIDING,
         mmbrl_pkg::MODE_FIXED, mmbrl_pkg::MODE_FIXED, mmbrl_pkg::MODE_TOKEN,
         mmbrl_pkg::MODE_SLIDING};
      logic [31:0] ph_rate  [12] = '{1000, 0, 32'hFFFF_FFFF, 5000, 1, 20000, 1000000, 0,
         3000, 32'hFFFF_FFFF, 100, 5000};
      logic [31:0] ph_burst [12] = '{2000, 0, 32'hFFFF_FFFF, 700, 1, 100, 5, 9, 1, 77,
         500, 3000};
      int ph_scale [12] = '{300, 3, 65535, 1000, 2, 600, 100, 2, 400, 65535, 80, 200};
      int ph_step  [12] = '{20, 20, 50, 20, 20, 5, 3, 50, 30, 100, 20, 10};
      lim_mode = mmbrl_pkg::MODE_TOKEN;
      lim_rate = {32'd0, mmbrl_pkg::RATE_RST};
      lim_burst = {32'd0, mmbrl_pkg::BURST_RST};
      clear_limiter(0);
      sum_granted = 0;
      sum_refused = 0;
      for (int m = 0; m < 4; m++) refusals[m] = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      // default registers: empty the bucket with maximum requests, then the edges
      r = '{mmbrl_pkg::ACT_ACQUIRE, 16'd0, 32'd0};
      pending_items.push_back(r);
      for (int i = 0; i < 17; i++) begin
         r = '{mmbrl_pkg::ACT_ACQUIRE, 16'hFFFF, 32'd0};
         pending_items.push_back(r);
      end
      r = '{mmbrl_pkg::ACT_CHECK, 16'hFFFF, 32'hFFFF_FFFF}; pending_items.push_back(r);
      r = '{mmbrl_pkg::ACT_WAIT, 16'hFFFF, 32'hFFFF_FFFF}; pending_items.push_back(r);
      r = '{mmbrl_pkg::ACT_WAIT, 16'd0, 32'd5}; pending_items.push_back(r);
      r = '{mmbrl_pkg::ACT_TICK, 16'd1, 32'd100}; pending_items.push_back(r);
      r = '{ACT_SPARE6, 16'hFFFF, 32'hFFFF_FFFF}; pending_items.push_back(r);
      r = '{ACT_SPARE7, 16'h5555, 32'hAAAA_AAAA}; pending_items.push_back(r);
      r = '{mmbrl_pkg::ACT_RESET, 16'd3, 32'h1234_5678}; pending_items.push_back(r);
      r = '{mmbrl_pkg::ACT_CLEAR, 16'd3, 32'd0}; pending_items.push_back(r);
      drain();
      csr_write(CSR_UNUSED, 32'hFFFF_FFFF);
      for (int ph = 0; ph < 12; ph++) begin
         quiet = (ph == 11);
         csr_write(mmbrl_pkg::CSR_MODE, {30'd0, ph_mode[ph]});
         csr_write(mmbrl_pkg::CSR_RATE, ph_rate[ph]);
         csr_write(mmbrl_pkg::CSR_BURST, ph_burst[ph]);
         bc_scale = ph_scale[ph];
         ms_step = ph_step[ph];
         for (int b = 0; b < 3; b++) begin
            for (int i = 0; i < 40; i++) pending_items.push_back(rand_item());
            drain();
         end
      end
      $display("ran %0d items over 12 register phases in all four modes", n_items);
      $display("results %0d, granted %0d, refused on full window store %0d",
               n_rsps, n_granted, n_full);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/mmbrl_pkg.sv
hw/rtl/mmbrl_front.sv
hw/rtl/mmbrl_back.sv
hw/rtl/multi_mode_byte_rate_limiter.sv
bench/tb_top.sv
